>>> src/ccit_pkg.sv
// ----------------------------------------------------------------------------
// ccit_pkg: shared types, constants and helpers of the child inverse transform
// Holds the fixed-point formats, the side payload that travels beside the
// angle, the CORDIC arctangent table function and the rounding and
// saturation helpers used by the datapath stages.
// ----------------------------------------------------------------------------
package ccit_pkg;

  // Fraction bits of every Q16.16 field.
  localparam int FRAC_BITS = 16;
  // Default number of CORDIC rotations.
  localparam int CORDIC_STEPS_DEF = 16;

  // Widths of the datapath.
  localparam int ANG_W  = 26;
  localparam int CS_W   = 18;
  localparam int XY_W   = 34;
  localparam int Z_W    = 42;
  localparam int WIDE_W = 38;
  localparam int ACC_W  = 66;

  // Angle constants in degrees with FRAC_BITS fraction bits.
  localparam logic signed [ANG_W:0] ANG_FULL    = (ANG_W + 1)'(360 * (1 << FRAC_BITS));
  localparam logic signed [ANG_W:0] ANG_HALF    = (ANG_W + 1)'(180 * (1 << FRAC_BITS));
  localparam logic signed [ANG_W:0] ANG_QUARTER = (ANG_W + 1)'(90 * (1 << FRAC_BITS));

  // Unit vector component of the sine and cosine outputs.
  localparam logic signed [CS_W-1:0] CS_ONE = CS_W'(1 << FRAC_BITS);

  // CORDIC start value: the inverse gain with 30 fraction bits.
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

  // Arctangent constants in degrees with 32 fraction bits.
  localparam longint DEG45_Q32       = 64'sd193273528320;
  localparam longint DEG_PER_RAD_Q32 = 64'sd246083499208;

  // Side fields that travel with the angle through the CORDIC.
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
  } side_t;

  // Quotient of two non-negative constants by shift and subtract.
  function automatic longint div_u(input longint n, input longint d);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = (r <<< 1) | ((n >>> b) & 64'sd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'sd1 <<< b);
      end
    end
    return q;
  endfunction

  // Arctangent of 2^-i in degrees, evaluated at elaboration by its series.
  function automatic longint atan_deg(input int unsigned i);
    longint      acc;
    longint      term;
    int unsigned k;
    acc = 0;
    if (i == 0) begin
      return DEG45_Q32;
    end
    for (k = 0; i * (2 * k + 1) < 63; k++) begin
      term = div_u(DEG_PER_RAD_Q32 >>> (i * (2 * k + 1)), longint'(2 * k + 1));
      acc  = (k[0]) ? acc - term : acc + term;
    end
    return acc;
  endfunction

  // Round half up while dropping FRAC_BITS fraction bits.
  function automatic logic signed [ACC_W-1:0] rnd_frac(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + ACC_W'(1 << (FRAC_BITS - 1));
    return t >>> FRAC_BITS;
  endfunction

  // Saturate to the intermediate width.
  function automatic logic signed [WIDE_W-1:0] wide_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'((64'sd1 <<< (WIDE_W - 1)) - 64'sd1);
    lo = -ACC_W'(64'sd1 <<< (WIDE_W - 1));
    if (v > hi) begin
      return hi[WIDE_W-1:0];
    end else if (v < lo) begin
      return lo[WIDE_W-1:0];
    end
    return v[WIDE_W-1:0];
  endfunction

endpackage

>>> src/ccit_cordic.sv
// ----------------------------------------------------------------------------
// ccit_cordic: angle reduction and pipelined sine and cosine
// Reduces the angle into [-90, 90] degrees with a sign flip, rotates one
// CORDIC step per stage, then rounds to Q2.16 and applies exact angles.
// ----------------------------------------------------------------------------
module ccit_cordic #(
  parameter int CORDIC_STEPS = ccit_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  logic                                 valid_i,
  input  logic signed [ccit_pkg::ANG_W-1:0]    angle_i,
  input  ccit_pkg::side_t                      side_i,
  output logic                                 valid_o,
  output logic signed [ccit_pkg::CS_W-1:0]     cos_o,
  output logic signed [ccit_pkg::CS_W-1:0]     sin_o,
  output ccit_pkg::side_t                      side_o
);

  localparam int XW = ccit_pkg::XY_W;
  localparam int ZW = ccit_pkg::Z_W;
  localparam int CW = ccit_pkg::CS_W;
  localparam int AW = ccit_pkg::ANG_W + 1;

  logic                 v_q    [CORDIC_STEPS+1];
  logic signed [XW-1:0] x_q    [CORDIC_STEPS+1];
  logic signed [XW-1:0] y_q    [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_q    [CORDIC_STEPS+1];
  logic                 flip_q [CORDIC_STEPS+1];
  logic                 zero_q [CORDIC_STEPS+1];
  logic                 right_q[CORDIC_STEPS+1];
  ccit_pkg::side_t      side_q [CORDIC_STEPS+1];

  logic signed [AW-1:0] a0, a1, a2;
  logic                 flip_d;

  // Reduce modulo 360 into [-180, 180), then fold into [-90, 90].
  always_comb begin
    a0 = AW'(angle_i);
    if (a0 >= ccit_pkg::ANG_HALF) begin
      a1 = a0 - ccit_pkg::ANG_FULL;
    end else if (a0 < -ccit_pkg::ANG_HALF) begin
      a1 = a0 + ccit_pkg::ANG_FULL;
    end else begin
      a1 = a0;
    end
    flip_d = 1'b0;
    if (a1 > ccit_pkg::ANG_QUARTER) begin
      a2     = a1 - ccit_pkg::ANG_HALF;
      flip_d = 1'b1;
    end else if (a1 < -ccit_pkg::ANG_QUARTER) begin
      a2     = a1 + ccit_pkg::ANG_HALF;
      flip_d = 1'b1;
    end else begin
      a2 = a1;
    end
  end

  // Entry stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (adv_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q[0]     <= ccit_pkg::CORDIC_GAIN;
      y_q[0]     <= '0;
      z_q[0]     <= ZW'(a2) <<< (32 - ccit_pkg::FRAC_BITS);
      flip_q[0]  <= flip_d;
      zero_q[0]  <= (a2 == '0);
      right_q[0] <= (a2 == ccit_pkg::ANG_QUARTER);
      side_q[0]  <= side_i;
    end
  end

  // One rotation per stage.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ATAN = ZW'(ccit_pkg::atan_deg(i));
    logic signed [XW-1:0] x_d, y_d;
    logic signed [ZW-1:0] z_d;

    always_comb begin
      if (z_q[i] >= 0) begin
        x_d = x_q[i] - (y_q[i] >>> i);
        y_d = y_q[i] + (x_q[i] >>> i);
        z_d = z_q[i] - ATAN;
      end else begin
        x_d = x_q[i] + (y_q[i] >>> i);
        y_d = y_q[i] - (x_q[i] >>> i);
        z_d = z_q[i] + ATAN;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (adv_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        x_q[i+1]     <= x_d;
        y_q[i+1]     <= y_d;
        z_q[i+1]     <= z_d;
        flip_q[i+1]  <= flip_q[i];
        zero_q[i+1]  <= zero_q[i];
        right_q[i+1] <= right_q[i];
        side_q[i+1]  <= side_q[i];
      end
    end
  end

  // Round to Q2.16, apply exact angles and the half-turn flip.
  logic signed [XW:0]   xr, yr;
  logic signed [CW-1:0] c_d, s_d;
  logic                 vr_q;
  logic signed [CW-1:0] c_q, s_q;
  ccit_pkg::side_t      sr_q;

  always_comb begin
    xr = (XW + 1)'(x_q[CORDIC_STEPS]) + (XW + 1)'(1 << (29 - ccit_pkg::FRAC_BITS));
    yr = (XW + 1)'(y_q[CORDIC_STEPS]) + (XW + 1)'(1 << (29 - ccit_pkg::FRAC_BITS));
    if (zero_q[CORDIC_STEPS]) begin
      c_d = ccit_pkg::CS_ONE;
      s_d = '0;
    end else if (right_q[CORDIC_STEPS]) begin
      c_d = '0;
      s_d = ccit_pkg::CS_ONE;
    end else begin
      c_d = xr[30-ccit_pkg::FRAC_BITS+CW-1:30-ccit_pkg::FRAC_BITS];
      s_d = yr[30-ccit_pkg::FRAC_BITS+CW-1:30-ccit_pkg::FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else if (adv_i) begin
      vr_q <= v_q[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      c_q  <= flip_q[CORDIC_STEPS] ? -c_d : c_d;
      s_q  <= flip_q[CORDIC_STEPS] ? -s_d : s_d;
      sr_q <= side_q[CORDIC_STEPS];
    end
  end

  assign valid_o = vr_q;
  assign cos_o   = c_q;
  assign sin_o   = s_q;
  assign side_o  = sr_q;

endmodule

>>> src/ccit_xform.sv
// ----------------------------------------------------------------------------
// ccit_xform: pivot placement and inverse rotation
// Eight stages: scaled pivot, negation, rotation products, rounded sums,
// pivot sums, offset from the pivot, inverse rotation products, final sums.
// ----------------------------------------------------------------------------
module ccit_xform (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  logic                                 valid_i,
  input  logic signed [ccit_pkg::CS_W-1:0]     cos_i,
  input  logic signed [ccit_pkg::CS_W-1:0]     sin_i,
  input  ccit_pkg::side_t                      side_i,
  output logic                                 valid_o,
  output logic signed [ccit_pkg::WIDE_W-1:0]   ux_o,
  output logic signed [ccit_pkg::WIDE_W-1:0]   uy_o,
  output logic signed [31:0]                   sx_o,
  output logic signed [31:0]                   sy_o
);

  localparam int CW = ccit_pkg::CS_W;
  localparam int WW = ccit_pkg::WIDE_W;
  localparam int AW = ccit_pkg::ACC_W;
  localparam int PW = CW + WW;
  localparam int NST = 8;

  logic            v_q   [NST];
  logic signed [CW-1:0] c_q  [6];
  logic signed [CW-1:0] s_q  [6];
  logic signed [CW-1:0] ns_q [6];
  ccit_pkg::side_t side_q[NST];

  logic signed [63:0]   pfx_q, pfy_q;
  logic signed [WW-1:0] fx_q, fy_q;
  logic signed [PW-1:0] p1_q, p2_q, p3_q, p4_q;
  logic signed [WW-1:0] dx_q, dy_q;
  logic signed [WW-1:0] x1_q, y1_q;
  logic signed [WW-1:0] tox_q, toy_q;
  logic signed [PW-1:0] q1_q, q2_q, q3_q, q4_q;
  logic signed [WW-1:0] ux_q, uy_q;

  // Valid bits move with the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (adv_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < NST; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  // Carried sine, cosine and side fields.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      c_q[0]    <= cos_i;
      s_q[0]    <= sin_i;
      ns_q[0]   <= -sin_i;
      side_q[0] <= side_i;
      for (int k = 1; k < 6; k++) begin
        c_q[k]  <= c_q[k-1];
        s_q[k]  <= s_q[k-1];
        ns_q[k] <= ns_q[k-1];
      end
      for (int k = 1; k < NST; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Arithmetic stages.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      // Pivot times scale.
      pfx_q <= side_i.ox * side_i.sx;
      pfy_q <= side_i.oy * side_i.sy;
      // Negated, rounded and saturated.
      fx_q  <= ccit_pkg::wide_sat(-AW'(ccit_pkg::wide_sat(ccit_pkg::rnd_frac(AW'(pfx_q)))));
      fy_q  <= ccit_pkg::wide_sat(-AW'(ccit_pkg::wide_sat(ccit_pkg::rnd_frac(AW'(pfy_q)))));
      // Rotation of the scaled pivot.
      p1_q  <= c_q[1] * fx_q;
      p2_q  <= ns_q[1] * fy_q;
      p3_q  <= s_q[1] * fx_q;
      p4_q  <= c_q[1] * fy_q;
      dx_q  <= ccit_pkg::wide_sat(ccit_pkg::rnd_frac(AW'(p1_q) + AW'(p2_q)));
      dy_q  <= ccit_pkg::wide_sat(ccit_pkg::rnd_frac(AW'(p3_q) + AW'(p4_q)));
      // World pivot.
      x1_q  <= ccit_pkg::wide_sat(AW'(dx_q) + AW'(side_q[3].cx) + AW'(side_q[3].ox));
      y1_q  <= ccit_pkg::wide_sat(AW'(dy_q) + AW'(side_q[3].cy) + AW'(side_q[3].oy));
      // Offset of the point from the pivot.
      tox_q <= ccit_pkg::wide_sat(AW'(side_q[4].px) - AW'(x1_q));
      toy_q <= ccit_pkg::wide_sat(AW'(side_q[4].py) - AW'(y1_q));
      // Rotation by minus the angle.
      q1_q  <= c_q[5] * tox_q;
      q2_q  <= s_q[5] * toy_q;
      q3_q  <= ns_q[5] * tox_q;
      q4_q  <= c_q[5] * toy_q;
      ux_q  <= ccit_pkg::wide_sat(ccit_pkg::rnd_frac(AW'(q1_q) + AW'(q2_q)));
      uy_q  <= ccit_pkg::wide_sat(ccit_pkg::rnd_frac(AW'(q3_q) + AW'(q4_q)));
    end
  end

  assign valid_o = v_q[NST-1];
  assign ux_o    = ux_q;
  assign uy_o    = uy_q;
  assign sx_o    = side_q[NST-1].sx;
  assign sy_o    = side_q[NST-1].sy;

endmodule

>>> src/ccit_divider.sv
// ----------------------------------------------------------------------------
// ccit_divider: two-lane pipelined fixed-point divider
// Divides each axis by its scale with round to nearest, halves away from
// zero, one quotient bit per stage, and saturates to 32 signed bits.
// ----------------------------------------------------------------------------
module ccit_divider (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  logic                                 valid_i,
  input  logic signed [ccit_pkg::WIDE_W-1:0]   num_i [2],
  input  logic signed [31:0]                   den_i [2],
  output logic                                 valid_o,
  output logic signed [31:0]                   res_o [2],
  output logic                                 zero_o
);

  localparam int WW  = ccit_pkg::WIDE_W;
  localparam int NW  = WW + ccit_pkg::FRAC_BITS + 1;
  localparam int QB  = 32;
  localparam int NST = QB + 3;

  logic v_q [NST];
  logic zf  [2];

  // Valid bits move with the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (adv_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < NST; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [NW-1:0] un_q;
    logic [31:0]   ud0_q;
    logic          neg0_q, zero0_q;
    logic [WW-1:0] anum;
    logic [31:0]   aden;

    logic [31:0] rem_q  [QB+1];
    logic [31:0] low_q  [QB+1];
    logic [31:0] quo_q  [QB+1];
    logic [31:0] ud_q   [QB+1];
    logic        neg_q  [QB+1];
    logic        zero_q [QB+1];
    logic        ovf_q  [QB+1];
    logic signed [31:0] res_q;

    // Magnitudes plus half the divisor for rounding.
    assign anum = num_i[l][WW-1] ? WW'(-num_i[l]) : WW'(num_i[l]);
    assign aden = den_i[l][31] ? 32'(-den_i[l]) : 32'(den_i[l]);

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        un_q    <= (NW'(anum) << ccit_pkg::FRAC_BITS) + NW'(aden >> 1);
        ud0_q   <= aden;
        neg0_q  <= num_i[l][WW-1] != den_i[l][31];
        zero0_q <= den_i[l] == '0;
        // Overflow check and split of the dividend.
        ovf_q[0]  <= {{(64 - NW){1'b0}}, un_q} >= {ud0_q, 32'b0};
        rem_q[0]  <= 32'(un_q[NW-1:32]);
        low_q[0]  <= un_q[31:0];
        quo_q[0]  <= '0;
        ud_q[0]   <= ud0_q;
        neg_q[0]  <= neg0_q;
        zero_q[0] <= zero0_q;
      end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar k = 0; k < QB; k++) begin : g_bit
      logic [32:0] t;
      logic        ge;
      assign t  = {rem_q[k], low_q[k][31]};
      assign ge = t >= {1'b0, ud_q[k]};

      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          rem_q[k+1]  <= ge ? 32'(t - {1'b0, ud_q[k]}) : t[31:0];
          low_q[k+1]  <= {low_q[k][30:0], 1'b0};
          quo_q[k+1]  <= {quo_q[k][30:0], ge};
          ud_q[k+1]   <= ud_q[k];
          neg_q[k+1]  <= neg_q[k];
          zero_q[k+1] <= zero_q[k];
          ovf_q[k+1]  <= ovf_q[k];
        end
      end
    end

    // Sign, saturation and zero scale.
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        if (zero_q[QB]) begin
          res_q <= '0;
        end else if (!neg_q[QB]) begin
          res_q <= (ovf_q[QB] || quo_q[QB][31]) ? 32'sh7fffffff : quo_q[QB];
        end else if (ovf_q[QB] || (quo_q[QB][31] && quo_q[QB][30:0] != '0)) begin
          res_q <= 32'sh80000000;
        end else begin
          res_q <= -quo_q[QB];
        end
      end
    end

    assign res_o[l] = res_q;
    assign zf[l]    = zero_q[QB];
  end

  // Zero flag register aligned with the result.
  logic zero_q;
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      zero_q <= zf[0] | zf[1];
    end
  end

  assign valid_o = v_q[NST-1];
  assign zero_o  = zero_q;

endmodule

>>> src/child_coordinate_inverse_transform.sv
// ----------------------------------------------------------------------------
// child_coordinate_inverse_transform: parent point into a child's local frame
// Top level: stream ports, CORDIC, pivot and rotation stages, divider.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the output is not stalled;
// each item passes through the one-rotation-per-stage CORDIC, the eight
// multiply and sum stages and the 32-stage quotient pipeline with its entry
// and exit stages. The whole pipeline advances together whenever the output
// register is empty or being taken, so a stall on the output holds every
// item in place.
module child_coordinate_inverse_transform #(
  parameter int CORDIC_STEPS = ccit_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // point_x, point_y, child_pos_x, child_pos_y, pivot_x, pivot_y, scale_x,
  // scale_y, angle_deg (26 bits), then zero fill
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // local_x, local_y
  output logic [63:0]  m_axis_tdata,
  // zero_scale
  output logic [0:0]   m_axis_tuser
);

  logic                                 adv;
  ccit_pkg::side_t                      side_in, side_cs;
  logic signed [ccit_pkg::ANG_W-1:0]    angle;
  logic                                 cs_valid, xf_valid, out_valid;
  logic signed [ccit_pkg::CS_W-1:0]     cos_v, sin_v;
  logic signed [ccit_pkg::WIDE_W-1:0]   ux, uy;
  logic signed [31:0]                   sx, sy;
  logic signed [ccit_pkg::WIDE_W-1:0]   num [2];
  logic signed [31:0]                   den [2];
  logic signed [31:0]                   res [2];
  logic                                 zero_flag;

  // Global advance: the output register is free or being taken.
  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;

  // Input field unpacking.
  assign side_in.px = s_axis_tdata[31:0];
  assign side_in.py = s_axis_tdata[63:32];
  assign side_in.cx = s_axis_tdata[95:64];
  assign side_in.cy = s_axis_tdata[127:96];
  assign side_in.ox = s_axis_tdata[159:128];
  assign side_in.oy = s_axis_tdata[191:160];
  assign side_in.sx = s_axis_tdata[223:192];
  assign side_in.sy = s_axis_tdata[255:224];
  assign angle      = s_axis_tdata[281:256];

  ccit_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s_axis_tvalid),
    .angle_i (angle),
    .side_i  (side_in),
    .valid_o (cs_valid),
    .cos_o   (cos_v),
    .sin_o   (sin_v),
    .side_o  (side_cs)
  );

  ccit_xform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (cs_valid),
    .cos_i   (cos_v),
    .sin_i   (sin_v),
    .side_i  (side_cs),
    .valid_o (xf_valid),
    .ux_o    (ux),
    .uy_o    (uy),
    .sx_o    (sx),
    .sy_o    (sy)
  );

  assign num[0] = ux;
  assign num[1] = uy;
  assign den[0] = sx;
  assign den[1] = sy;

  ccit_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (xf_valid),
    .num_i   (num),
    .den_i   (den),
    .valid_o (out_valid),
    .res_o   (res),
    .zero_o  (zero_flag)
  );

  // Output item.
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {res[1], res[0]};
  assign m_axis_tuser  = zero_flag;

  // A flagged zero scale forces at least one axis to zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> res[0] == '0 || res[1] == '0)
    else $error("zero scale flagged without a zeroed axis");

  // A held output item stalls the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while the output is stalled");

  // Sine and cosine stay near the unit circle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cs_valid |-> cos_v <= 18'sd66000 && cos_v >= -18'sd66000
                 && sin_v <= 18'sd66000 && sin_v >= -18'sd66000)
    else $error("sine or cosine out of range");

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the child coordinate inverse transform
// Sends parent points with random child poses through the stream input and
// checks every result against a fixed-point model of the transform, under
// random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb;

  // Expected contents of one result item.
  typedef struct {
    logic [31:0] lx;
    logic [31:0] ly;
    logic        zs;
  } local_pt_t;

  // Fields of one input item.
  typedef struct {
    logic [31:0] px, py, cx, cy, ox, oy, sx, sy;
    logic [25:0] ang;
  } pose_t;

  localparam longint ONE_Q32 = 64'sd1 <<< 32;
  localparam longint Q16_ONE = 64'sd65536;
  localparam int     LATENCY = ccit_pkg::CORDIC_STEPS_DEF + 45;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  local_pt_t expected_pts[$];
  int        n_sent = 0;
  int        n_checked = 0;
  int        n_errors = 0;
  int        n_zero_scale = 0;
  bit        no_gaps = 1'b0;
  int        stall_left = 0;

  child_coordinate_inverse_transform dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // Clock and reset.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Saturate to the 38-bit intermediate range.
  function automatic longint sat38(input longint v);
    longint hi, lo;
    hi = (64'sd1 <<< 37) - 1;
    lo = -(64'sd1 <<< 37);
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // Drop n fraction bits, rounding half up.
  function automatic longint round_drop(input longint v, input int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  // Arctangent of 2^-i in degrees with 32 fraction bits.
  function automatic longint arctan_step(input int i);
    longint acc, term;
    acc = 0;
    if (i == 0) return 64'sd193273528320;
    for (int k = 0; i * (2 * k + 1) < 63; k++) begin
      term = (64'sd246083499208 >>> (i * (2 * k + 1))) / longint'(2 * k + 1);
      acc = k[0] ? acc - term : acc + term;
    end
    return acc;
  endfunction

  // Cosine and sine of an angle in degrees, FRAC_BITS fraction bits.
  task automatic sin_cos_deg(input longint ang, output longint c, output longint s);
    longint full, half, quarter, r, x, y, z, dx, dy;
    bit     flip;
    full = 360 * ONE_Q32;
    half = 180 * ONE_Q32;
    quarter = 90 * ONE_Q32;
    flip = 1'b0;
    r = (ang * Q16_ONE) % full;
    if (r < 0) r += full;
    if (r >= half) r -= full;
    if (r > quarter) begin
      r -= half;
      flip = 1'b1;
    end else if (r < -quarter) begin
      r += half;
      flip = 1'b1;
    end
    if (r == 0) begin
      x = 64'sd1 <<< 30;
      y = 0;
    end else if (r == quarter) begin
      x = 0;
      y = 64'sd1 <<< 30;
    end else begin
      x = 64'sd652032874;
      y = 0;
      z = r;
      for (int i = 0; i < ccit_pkg::CORDIC_STEPS_DEF; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= arctan_step(i);
        end else begin
          x += dx; y -= dy; z += arctan_step(i);
        end
      end
    end
    c = round_drop(x, 30 - ccit_pkg::FRAC_BITS);
    s = round_drop(y, 30 - ccit_pkg::FRAC_BITS);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endtask

  // Quotient in Q16.16, rounded to nearest with halves away from zero.
  function automatic longint quotient_q(input longint num, input longint den);
    longint          n, q;
    longint unsigned un, ud;
    n = num * Q16_ONE;
    un = n < 0 ? -n : n;
    ud = den < 0 ? -den : den;
    q = longint'((un + ud / 2) / ud);
    if ((n < 0) != (den < 0)) q = -q;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  // Point in the child's local frame for one pose.
  task automatic child_local_point(input pose_t p, output local_pt_t r);
    longint px, py, cx, cy, ox, oy, sx, sy, c, s, fx, fy, x1, y1, tox, toy, ux, uy;
    px = longint'(signed'(p.px)); py = longint'(signed'(p.py));
    cx = longint'(signed'(p.cx)); cy = longint'(signed'(p.cy));
    ox = longint'(signed'(p.ox)); oy = longint'(signed'(p.oy));
    sx = longint'(signed'(p.sx)); sy = longint'(signed'(p.sy));
    sin_cos_deg(longint'(signed'(p.ang)), c, s);
    fx = sat38(-sat38(round_drop(ox * sx, 16)));
    fy = sat38(-sat38(round_drop(oy * sy, 16)));
    x1 = sat38(sat38(round_drop(c * fx - s * fy, 16)) + cx + ox);
    y1 = sat38(sat38(round_drop(s * fx + c * fy, 16)) + cy + oy);
    tox = sat38(px - x1);
    toy = sat38(py - y1);
    ux = sat38(round_drop(c * tox + s * toy, 16));
    uy = sat38(round_drop(-s * tox + c * toy, 16));
    r.zs = (sx == 0) || (sy == 0);
    r.lx = (sx == 0) ? 32'd0 : 32'(quotient_q(ux, sx));
    r.ly = (sy == 0) ? 32'd0 : 32'(quotient_q(uy, sy));
  endtask

  // Send one item, wait for its acceptance, then sometimes idle for a random gap.
  task automatic send_pose(input pose_t p);
    local_pt_t e;
    int        gap, r;
    s_axis_tdata <= {6'd0, p.ang, p.sy, p.sx, p.oy, p.ox, p.cy, p.cx, p.py, p.px};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    child_local_point(p, e);
    expected_pts = {expected_pts, e};
    n_sent++;
    r = $urandom_range(0, 99);
    gap = no_gaps || r < 60 ? 0 : (r < 92 ? $urandom_range(1, 3) : $urandom_range(10, 40));
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Result check and output stall pattern.
  always @(posedge clk_i) begin
    local_pt_t e;
    int        r;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_checked++;
        if (expected_pts.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result item %h", m_axis_tdata);
        end else begin
          e = expected_pts.pop_front();
          if (m_axis_tuser[0]) n_zero_scale++;
          if (m_axis_tdata[31:0] !== e.lx || m_axis_tdata[63:32] !== e.ly ||
              m_axis_tuser[0] !== e.zs) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch at result %0d: expected x %h y %h zero %b, got x %h y %h zero %b",
                       n_checked, e.lx, e.ly, e.zs, m_axis_tdata[31:0],
                       m_axis_tdata[63:32], m_axis_tuser[0]);
          end
        end
      end
      // Mostly ready, with short and occasional long stalls.
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (no_gaps || r < 75) begin
          m_axis_tready <= 1'b1;
        end else begin
          stall_left = r < 95 ? $urandom_range(0, 2) : $urandom_range(10, 40);
          m_axis_tready <= 1'b0;
        end
      end
    end
  end

  // Random Q16.16 value: full range, small, exact integers, or zero (one if zero is not allowed).
  function automatic logic [31:0] rand_q(input bit allow_zero);
    int r;
    logic [31:0] v;
    r = $urandom_range(0, 9);
    if (r < 3) v = $urandom();
    else if (r < 7) v = 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    else if (r < 9) v = 32'(($signed($urandom_range(0, 64)) - 32) * 65536);
    else v = allow_zero ? 32'd0 : 32'h0001_0000;
    return v;
  endfunction

  // Random scale: mostly moderate, sometimes zero or extreme.
  function automatic logic [31:0] rand_scale();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'd0;
    if (r < 4) return $urandom();
    if (r < 6) return 32'($signed($urandom_range(0, 64)) - 32);
    return 32'(($urandom_range(0, 1) ? -1 : 1) * $signed($urandom_range(1 << 13, 1 << 19)));
  endfunction

  // Random angle: any value from -360 to 360 degrees, or a multiple of 90 degrees.
  function automatic logic [25:0] rand_angle();
    if ($urandom_range(0, 4) == 0)
      return 26'(($signed($urandom_range(0, 8)) - 4) * 90 * 65536);
    return 26'($signed($urandom_range(0, 47185920)) - 23592960);
  endfunction

  // Field extremes, zero scales and exact angles.
  task automatic test_directed();
    pose_t p;
    int    angles[8] = '{0, 90, 180, 270, -90, -180, 360, -360};
    foreach (angles[i]) begin
      p = '{32'h0003_0000, 32'hFFFE_0000, 32'h0001_0000, 32'h0000_8000,
            32'h0000_4000, 32'hFFFF_0000, 32'h0002_0000, 32'h0000_8000,
            26'(angles[i] * 65536)};
      send_pose(p);
    end
    p = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
          32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 26'h0000001};
    send_pose(p);
    p = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 26'h2000001};
    send_pose(p);
    p = '{32'h0010_0000, 32'h0020_0000, 32'd0, 32'd0, 32'd0, 32'd0,
          32'd0, 32'h0001_0000, 26'(23592960)};
    send_pose(p);
    p.sx = 32'h0001_0000; p.sy = 32'd0; p.ang = 26'(-23592960);
    send_pose(p);
    p.sx = 32'd0; p.ang = 26'(45 * 65536);
    send_pose(p);
    p = '{32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0, 32'h0000_8000, 32'h0000_8000,
          32'h0001_0000, 32'hFFFF_0000, 26'(30 * 65536 + 1)};
    send_pose(p);
  endtask

  // Random poses, with stretches that run without any idling.
  task automatic test_random(input int n_items);
    pose_t p;
    for (int i = 0; i < n_items; i++) begin
      if (i % 200 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      p.px = rand_q(1'b1); p.py = rand_q(1'b1);
      p.cx = rand_q(1'b1); p.cy = rand_q(1'b1);
      p.ox = rand_q(1'b1); p.oy = rand_q(1'b1);
      p.sx = rand_scale(); p.sy = rand_scale();
      p.ang = rand_angle();
      send_pose(p);
    end
    no_gaps = 1'b0;
  endtask

  // Test sequence.
  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    test_directed();
    test_random(2000);
    s_axis_tvalid <= 1'b0;
    while (expected_pts.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    $display("Sent %0d poses and checked %0d results, %0d of them with a zero scale.",
             n_sent, n_checked, n_zero_scale);
    if (n_errors == 0 && expected_pts.size() == 0) begin
      $display("[child_coordinate_inverse_transform] OK");
    end else begin
      $display("%0d failures", n_errors);
      $display("[child_coordinate_inverse_transform] ERROR");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #20000000;
    $display("[child_coordinate_inverse_transform] ERROR");
    $finish;
  end

endmodule
